[hw/rtl/lzr_pkg.sv]
package lzr_pkg;

  // Line and kernel sizing
  localparam int MAX_LEN      = 1024;
  localparam int MAX_TAPS     = 64;
  localparam int KERNEL_STEPS = 256;
  localparam int TAB_LEN      = 3 * KERNEL_STEPS;

  localparam int LEN_W  = $clog2(MAX_LEN);
  localparam int CFG_W  = LEN_W + 1;
  localparam int TAB_AW = $clog2(TAB_LEN);
  localparam int KEPT_W = $clog2(MAX_TAPS + 1);
  localparam int W_W    = 16;          // signed Q14 kernel weight
  localparam int W_FRAC = 14;
  localparam int POS_W  = 2 * LEN_W + 5;
  localparam int ACC_W  = 32;
  localparam int TOT_W  = W_W + KEPT_W;
  localparam int PIX_W  = 32;

  // Shared divider sizing
  localparam int DIV_NW = 32;
  localparam int DIV_DW = 24;
  localparam int DIV_QW = 24;
  localparam int DIV_CW = 5;
  localparam int LO_QBITS  = 2 * LEN_W + 2;
  localparam int TI_QBITS  = $clog2(TAB_LEN + 1);
  localparam int FIN_QBITS = 8;

  localparam logic [63:0] PI_Q30  = 64'd3373259426;
  localparam logic [63:0] ONE_Q30 = 64'd1073741824;

  typedef enum logic {
    OP_WRITE   = 1'b0,
    OP_COMPUTE = 1'b1
  } opcode_e;

  typedef enum logic {
    REG_SOURCE_LEN = 1'b0,
    REG_TARGET_LEN = 1'b1
  } reg_idx_e;

  typedef struct packed {
    opcode_e          opcode;
    logic [LEN_W-1:0] pixel_index;
    logic [7:0]       red_in;
    logic [7:0]       green_in;
    logic [7:0]       blue_in;
    logic [7:0]       alpha_in;
  } in_item_t;

  typedef struct packed {
    logic [LEN_W-1:0] target_index;
    logic [7:0]       red_out;
    logic [7:0]       green_out;
    logic [7:0]       blue_out;
    logic [7:0]       alpha_out;
    logic             taps_clipped;
  } out_item_t;

  typedef struct packed {
    logic [DIV_NW-1:0] num;
    logic [DIV_DW-1:0] den;
    logic [DIV_CW-1:0] qbits;
  } div_req_t;

  typedef logic signed [W_W-1:0] ktab_t [TAB_LEN];

  // long division used while the kernel table is built
  function automatic logic [63:0] cdiv(input logic [63:0] num, input logic [63:0] den);
    logic [63:0] q;
    logic [64:0] r;
    q = '0;
    r = '0;
    for (int b = 63; b >= 0; b--) begin
      r = {r[63:0], num[b]};
      if (r >= {1'b0, den}) begin
        r    = r - {1'b0, den};
        q[b] = 1'b1;
      end
    end
    return q;
  endfunction

  // sin(pi*n/d) in Q30, d = KERNEL_STEPS or 3*KERNEL_STEPS
  function automatic logic signed [63:0] sin_q30(input logic [63:0] n_in, input logic wide);
    logic [63:0] d;
    logic [63:0] n;
    logic [63:0] th;
    logic [63:0] t2;
    logic [63:0] p;
    logic signed [63:0] sum;
    logic neg;
    d = wide ? 64'(TAB_LEN) : 64'(KERNEL_STEPS);
    n = n_in - cdiv(n_in, 2 * d) * (2 * d);
    neg = (n >= d);
    if (neg) n = n - d;
    if (2 * n > d) n = d - n;
    th = cdiv(PI_Q30 * n, d);
    t2 = (th * th) >> 30;
    p = th;
    sum = $signed(th);
    for (int k = 1; k <= 5; k++) begin
      p = cdiv((p * t2) >> 30, 64'((2 * k) * (2 * k + 1)));
      if ((k % 2) == 1) sum = sum - $signed(p);
      else sum = sum + $signed(p);
    end
    return neg ? -sum : sum;
  endfunction

  // sinc(n/d) in Q30
  function automatic logic signed [63:0] sinc_q30(input logic [63:0] n, input logic wide);
    logic [63:0] d;
    logic [63:0] th;
    logic [63:0] mag;
    logic signed [63:0] s;
    d = wide ? 64'(TAB_LEN) : 64'(KERNEL_STEPS);
    if (n == 64'd0) return $signed(ONE_Q30);
    th = cdiv(PI_Q30 * n, d);
    s = sin_q30(n, wide);
    mag = cdiv((s < 0 ? 64'(-s) : 64'(s)) << 30, th);
    return (s < 0) ? -$signed(mag) : $signed(mag);
  endfunction

  // Sampled Lanczos-3 kernel, Q14
  function automatic ktab_t build_ktab();
    ktab_t t;
    logic signed [63:0] a;
    logic signed [63:0] b;
    logic [63:0] ua;
    logic [63:0] ub;
    logic [63:0] m;
    logic neg;
    for (int i = 0; i < TAB_LEN; i++) begin
      a = sinc_q30(64'(i), 1'b0);
      b = sinc_q30(64'(i), 1'b1);
      neg = (a < 0) != (b < 0);
      ua = (a < 0) ? 64'(-a) : 64'(a);
      ub = (b < 0) ? 64'(-b) : 64'(b);
      m = (ua * ub + (64'd1 << 45)) >> 46;
      t[i] = neg ? -W_W'(m) : W_W'(m);
    end
    return t;
  endfunction

  localparam ktab_t KTAB = build_ktab();

endpackage

[hw/rtl/lanczos3_line_resampler.sv]
// Write items are accepted back to back.
// A compute item first divides to find the first candidate tap, then steps through the
// candidates, skipping those outside the kernel support and handling each tap inside it
// with a tap index divide, a table read and a line store read, then runs up to four
// normalizing divides and raises a one-cycle result strobe.
// One item at a time; busy stays high through the result strobe. Results cannot stall.
// Reset: async active low; lengths return to 1, line store contents undefined.
module lanczos3_line_resampler import lzr_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start,
  output logic             busy,
  input  in_item_t         item_i,
  output logic             result_valid_o,
  output out_item_t        result_o,
  input  logic             cfg_valid_i,
  output logic             cfg_ready_o,
  input  reg_idx_e         cfg_index_i,
  input  logic [CFG_W-1:0] cfg_data_i
);

  typedef enum logic [3:0] {
    ST_IDLE, ST_LO_GO, ST_LO_WAIT, ST_SCAN, ST_TI_GO, ST_TI_WAIT,
    ST_KERN, ST_PIX, ST_FIN_GO, ST_FIN_WAIT, ST_OUT
  } state_e;

  state_e state_q;
  logic [CFG_W-1:0] src_len_q, tgt_len_q;
  logic [CFG_W-1:0] src_eff, tgt_eff, max_eff;

  logic [LEN_W-1:0]        idx_q;
  logic signed [POS_W-1:0] a_q, s_q, n_q;
  logic [CFG_W:0]          d_q, tgt2_q;
  logic [CFG_W-1:0]        src_q;
  logic signed [ACC_W-1:0] acc_q [4];
  logic signed [TOT_W-1:0] tot_q;
  logic signed [W_W-1:0]   w_q;
  logic [KEPT_W-1:0]       kept_q;
  logic                    clip_q;
  logic [1:0]              ch_q;
  logic [7:0]              res_q [4];

  logic accept;
  logic [2*LEN_W+1:0]      prod;
  logic signed [POS_W-1:0] a_new, d3_s, tgt2_s, d_s, x_s, abs_x, lo_s, rfl_s, abs_n;
  logic signed [POS_W-1:0] src_m1, si_s;
  logic [LEN_W-1:0]        si;
  logic                    scan_end, near;

  logic              div_start, div_done;
  div_req_t          div_req;
  logic [DIV_QW-1:0] div_quot;
  logic [DIV_NW-1:0] div_rem;

  logic signed [W_W-1:0] rom_w;
  logic [PIX_W-1:0]      px;

  logic signed [ACC_W-1:0] acc_sel;
  logic [DIV_NW-1:0]       fin_ua, fin_ub, fin_num;
  logic [DIV_NW-1:0]       fin_den;
  logic                    fin_neg, fin_ovf;

  // effective lengths
  always_comb begin
    src_eff = src_len_q;
    if (src_len_q == '0) src_eff = CFG_W'(1);
    else if (src_len_q > CFG_W'(MAX_LEN)) src_eff = CFG_W'(MAX_LEN);
    tgt_eff = tgt_len_q;
    if (tgt_len_q == '0) tgt_eff = CFG_W'(1);
    else if (tgt_len_q > CFG_W'(MAX_LEN)) tgt_eff = CFG_W'(MAX_LEN);
    max_eff = (src_eff > tgt_eff) ? src_eff : tgt_eff;
  end

  // configuration registers
  assign cfg_ready_o = 1'b1;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      src_len_q <= CFG_W'(1);
      tgt_len_q <= CFG_W'(1);
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        REG_SOURCE_LEN: src_len_q <= cfg_data_i;
        REG_TARGET_LEN: tgt_len_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign busy   = (state_q != ST_IDLE);
  assign accept = start && !busy;

  // kernel center and geometry
  assign prod   = {item_i.pixel_index, 1'b1} * src_eff;
  assign a_new  = $signed(POS_W'(prod)) - $signed(POS_W'(tgt_eff));
  assign d_s    = $signed(POS_W'(d_q));
  assign d3_s   = $signed(POS_W'({d_q, 1'b0})) + d_s;
  assign tgt2_s = $signed(POS_W'(tgt2_q));
  assign x_s    = a_q - d3_s;
  assign abs_x  = x_s[POS_W-1] ? -x_s : x_s;
  assign lo_s   = x_s[POS_W-1]
                ? -($signed(POS_W'(div_quot)) + POS_W'(div_rem != '0))
                : $signed(POS_W'(div_quot));
  assign rfl_s  = (x_s[POS_W-1] && div_rem != '0)
                ? tgt2_s - $signed(POS_W'(div_rem))
                : (x_s[POS_W-1] ? '0 : $signed(POS_W'(div_rem)));

  // tap scan conditions
  assign abs_n    = n_q[POS_W-1] ? -n_q : n_q;
  assign scan_end = (n_q + tgt2_s + d3_s) < 0;
  assign near     = abs_n < d3_s;

  // edge clamp of source index
  assign src_m1 = $signed(POS_W'(src_q)) - POS_W'(1);
  assign si_s   = s_q[POS_W-1] ? '0 : ((s_q > src_m1) ? src_m1 : s_q);
  assign si     = si_s[LEN_W-1:0];

  // normalization operands
  assign acc_sel = acc_q[ch_q];
  assign fin_neg = acc_sel[ACC_W-1] != tot_q[TOT_W-1];
  assign fin_ua  = acc_sel[ACC_W-1] ? DIV_NW'(-acc_sel) : DIV_NW'(acc_sel);
  assign fin_ub  = (tot_q == '0) ? DIV_NW'(1 << W_FRAC)
                 : (tot_q[TOT_W-1] ? DIV_NW'(-tot_q) : DIV_NW'(tot_q));
  assign fin_num = {fin_ua[DIV_NW-2:0], 1'b0} + fin_ub;
  assign fin_den = {fin_ub[DIV_NW-2:0], 1'b0};
  assign fin_ovf = fin_num >= (fin_den << FIN_QBITS);

  // divider requests
  always_comb begin
    div_start = 1'b0;
    div_req   = '0;
    unique case (state_q)
      ST_LO_GO: begin
        div_start     = 1'b1;
        div_req.num   = DIV_NW'(abs_x);
        div_req.den   = DIV_DW'(tgt2_q);
        div_req.qbits = DIV_CW'(LO_QBITS);
      end
      ST_TI_GO: begin
        div_start     = 1'b1;
        div_req.num   = DIV_NW'(abs_n) * DIV_NW'(2 * KERNEL_STEPS) + DIV_NW'(d_q);
        div_req.den   = DIV_DW'({d_q, 1'b0});
        div_req.qbits = DIV_CW'(TI_QBITS);
      end
      ST_FIN_GO: begin
        div_start     = !fin_ovf;
        div_req.num   = fin_num;
        div_req.den   = DIV_DW'(fin_den);
        div_req.qbits = DIV_CW'(FIN_QBITS);
      end
      default: ;
    endcase
  end

  lzr_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .req_i   (div_req),
    .done_o  (div_done),
    .quot_o  (div_quot),
    .rem_o   (div_rem)
  );

  lzr_kern_rom u_kern (
    .clk_i  (clk_i),
    .addr_i (div_quot[TAB_AW-1:0]),
    .w_o    (rom_w)
  );

  lzr_ram #(
    .WIDTH (PIX_W),
    .DEPTH (MAX_LEN)
  ) u_line (
    .clk_i   (clk_i),
    .we_i    (accept && item_i.opcode == OP_WRITE),
    .waddr_i (item_i.pixel_index),
    .wdata_i ({item_i.alpha_in, item_i.blue_in, item_i.green_in, item_i.red_in}),
    .raddr_i (si),
    .rdata_o (px)
  );

  // sequencer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      unique case (state_q)
        ST_IDLE: begin
          if (accept && item_i.opcode == OP_COMPUTE
              && {1'b0, item_i.pixel_index} < tgt_eff) begin
            state_q <= ST_LO_GO;
          end
        end
        ST_LO_GO:   state_q <= ST_LO_WAIT;
        ST_LO_WAIT: if (div_done) state_q <= ST_SCAN;
        ST_SCAN: begin
          if (scan_end) state_q <= ST_FIN_GO;
          else if (near) state_q <= ST_TI_GO;
        end
        ST_TI_GO: state_q <= ST_TI_WAIT;
        ST_TI_WAIT: begin
          if (div_done) begin
            if (div_quot >= DIV_QW'(TAB_LEN)) state_q <= ST_SCAN;
            else state_q <= ST_KERN;
          end
        end
        ST_KERN: begin
          if (rom_w == '0 || kept_q == KEPT_W'(MAX_TAPS)) state_q <= ST_SCAN;
          else state_q <= ST_PIX;
        end
        ST_PIX: state_q <= ST_SCAN;
        ST_FIN_GO: begin
          if (!fin_ovf) state_q <= ST_FIN_WAIT;
          else if (ch_q == 2'd3) state_q <= ST_OUT;
        end
        ST_FIN_WAIT: begin
          if (div_done) state_q <= (ch_q == 2'd3) ? ST_OUT : ST_FIN_GO;
        end
        ST_OUT: state_q <= ST_IDLE;
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    unique case (state_q)
      ST_IDLE: begin
        idx_q  <= item_i.pixel_index;
        a_q    <= a_new;
        d_q    <= {max_eff, 1'b0};
        tgt2_q <= {tgt_eff, 1'b0};
        src_q  <= src_eff;
        for (int c = 0; c < 4; c++) acc_q[c] <= '0;
        tot_q  <= '0;
        kept_q <= '0;
        clip_q <= 1'b0;
        ch_q   <= '0;
      end
      ST_LO_WAIT: begin
        if (div_done) begin
          s_q <= lo_s;
          n_q <= d3_s + rfl_s;
        end
      end
      ST_SCAN: begin
        if (!scan_end && !near) begin
          s_q <= s_q + POS_W'(1);
          n_q <= n_q - tgt2_s;
        end
      end
      ST_TI_WAIT: begin
        if (div_done && div_quot >= DIV_QW'(TAB_LEN)) begin
          s_q <= s_q + POS_W'(1);
          n_q <= n_q - tgt2_s;
        end
      end
      ST_KERN: begin
        w_q <= rom_w;
        if (rom_w != '0 && kept_q == KEPT_W'(MAX_TAPS)) clip_q <= 1'b1;
        if (rom_w == '0 || kept_q == KEPT_W'(MAX_TAPS)) begin
          s_q <= s_q + POS_W'(1);
          n_q <= n_q - tgt2_s;
        end
      end
      ST_PIX: begin
        for (int c = 0; c < 4; c++) begin
          acc_q[c] <= acc_q[c]
                    + ACC_W'($signed({1'b0, px[8*c +: 8]})) * ACC_W'(w_q);
        end
        tot_q  <= tot_q + TOT_W'(w_q);
        kept_q <= kept_q + KEPT_W'(1);
        s_q    <= s_q + POS_W'(1);
        n_q    <= n_q - tgt2_s;
      end
      ST_FIN_GO: begin
        if (fin_ovf) begin
          res_q[ch_q] <= fin_neg ? 8'd0 : 8'd255;
          ch_q        <= ch_q + 2'd1;
        end
      end
      ST_FIN_WAIT: begin
        if (div_done) begin
          res_q[ch_q] <= fin_neg ? 8'd0 : div_quot[7:0];
          ch_q        <= ch_q + 2'd1;
        end
      end
      default: ;
    endcase
  end

  // result
  assign result_valid_o          = (state_q == ST_OUT);
  assign result_o.target_index   = idx_q;
  assign result_o.red_out        = res_q[0];
  assign result_o.green_out      = res_q[1];
  assign result_o.blue_out       = res_q[2];
  assign result_o.alpha_out      = res_q[3];
  assign result_o.taps_clipped   = clip_q;

endmodule

[hw/rtl/lzr_ram.sv]
module lzr_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) mem_q[waddr_i] <= wdata_i;
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

[hw/rtl/lzr_kern_rom.sv]
module lzr_kern_rom import lzr_pkg::*; (
  input  logic                  clk_i,
  input  logic [TAB_AW-1:0]     addr_i,
  output logic signed [W_W-1:0] w_o
);

  logic signed [W_W-1:0] w_q;

  // registered kernel table read
  always_ff @(posedge clk_i) begin
    w_q <= KTAB[addr_i];
  end

  assign w_o = w_q;

endmodule

[hw/rtl/lzr_div.sv]
module lzr_div import lzr_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  div_req_t          req_i,
  output logic              done_o,
  output logic [DIV_QW-1:0] quot_o,
  output logic [DIV_NW-1:0] rem_o
);

  localparam int DSH_W = DIV_DW + 32;

  logic              busy_q, busy_d;
  logic              done_q, done_d;
  logic [DIV_CW-1:0] cnt_q, cnt_d;
  logic [DIV_NW-1:0] rem_q, rem_d;
  logic [DSH_W-1:0]  dsh_q, dsh_d;
  logic [DIV_QW-1:0] quot_q, quot_d;
  logic              fits;

  assign fits = DSH_W'(rem_q) >= dsh_q;

  // restoring divide, one quotient bit a cycle
  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    dsh_d  = dsh_q;
    quot_d = quot_q;
    if (start_i) begin
      busy_d = 1'b1;
      rem_d  = req_i.num;
      dsh_d  = DSH_W'(req_i.den) << (req_i.qbits - DIV_CW'(1));
      quot_d = '0;
      cnt_d  = req_i.qbits - DIV_CW'(1);
    end else if (busy_q) begin
      if (fits) rem_d = rem_q - DIV_NW'(dsh_q);
      quot_d = {quot_q[DIV_QW-2:0], fits};
      dsh_d  = dsh_q >> 1;
      cnt_d  = cnt_q - DIV_CW'(1);
      if (cnt_q == '0) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cnt_q  <= cnt_d;
    rem_q  <= rem_d;
    dsh_q  <= dsh_d;
    quot_q <= quot_d;
  end

  assign done_o = done_q;
  assign quot_o = quot_q;
  assign rem_o  = rem_q;

endmodule

[sim/tb.sv]
`timescale 1ns / 100ps

module tb import lzr_pkg::*; ();

  localparam int KTAB_N = 3 * KERNEL_STEPS;
  localparam int LIMIT  = 20_000_000;

  logic             clk_i = 1'b0;
  logic             rst_ni = 1'b0;
  logic             start = 1'b0;
  logic             busy;
  in_item_t         item_i = '0;
  logic             result_valid_o;
  out_item_t        result_o;
  logic             cfg_valid_i = 1'b0;
  logic             cfg_ready_o;
  reg_idx_e         cfg_index_i = REG_SOURCE_LEN;
  logic [CFG_W-1:0] cfg_data_i = '0;

  lanczos3_line_resampler uut (.*);

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Kernel table, built in the testbench's own arithmetic
  longint ktab [KTAB_N];
  logic [31:0] line_mem [MAX_LEN];
  int unsigned src_len, tgt_len;

  in_item_t  pending_q [$];
  out_item_t pixel_exp_q [$];
  int        errors = 0;
  int        n_sent = 0;
  int        gap = 0;
  bit        hold = 1'b0;
  longint    cycles = 0;

  function automatic void queue_item(in_item_t it);
    pending_q = {pending_q, it};
  endfunction

  function automatic longint sin_fx(longint unsigned n, longint unsigned d);
    longint unsigned th, t2, p;
    longint sum;
    bit neg;
    n = n % (2 * d);
    neg = n >= d;
    if (neg) n -= d;
    if (2 * n > d) n = d - n;
    th = 64'd3373259426 * n / d;
    t2 = (th * th) >> 30;
    p = th;
    sum = th;
    for (int k = 1; k <= 5; k++) begin
      p = ((p * t2) >> 30) / ((2 * k) * (2 * k + 1));
      if (k % 2) sum -= p;
      else sum += p;
    end
    return neg ? -sum : sum;
  endfunction

  function automatic longint sinc_fx(longint unsigned n, longint unsigned d);
    longint unsigned th, mg;
    longint s;
    if (n == 0) return 64'd1073741824;
    th = 64'd3373259426 * n / d;
    s = sin_fx(n, d);
    mg = (longint'(s < 0 ? -s : s) << 30) / th;
    return s < 0 ? -longint'(mg) : longint'(mg);
  endfunction

  function automatic longint floor_q(longint a, longint b);
    longint q;
    q = a / b;
    if ((a % b) != 0 && a < 0) q--;
    return q;
  endfunction

  function automatic longint round_q(longint a, longint b);
    bit neg;
    longint unsigned ua, ub;
    neg = (a < 0) != (b < 0);
    ua = a < 0 ? -a : a;
    ub = b < 0 ? -b : b;
    return neg ? -longint'((2 * ua + ub) / (2 * ub)) : longint'((2 * ua + ub) / (2 * ub));
  endfunction

  function automatic int unsigned clamp_len(int unsigned v);
    if (v == 0) return 1;
    if (v > MAX_LEN) return MAX_LEN;
    return v;
  endfunction

  // Update the line store or predict one resampled pixel; an out-of-range target index predicts nothing
  function automatic void resample_pixel(in_item_t it);
    longint src, tgt, a, d, lo, hi, n, un, ti, w, si, total;
    longint acc [4];
    int kept;
    bit clipped;
    out_item_t r;
    if (it.opcode == OP_WRITE) begin
      line_mem[it.pixel_index] = {it.alpha_in, it.blue_in, it.green_in, it.red_in};
      return;
    end
    src = clamp_len(src_len);
    tgt = clamp_len(tgt_len);
    if (it.pixel_index >= tgt) return;
    total = 0; kept = 0; clipped = 0;
    foreach (acc[c]) acc[c] = 0;
    a = (2 * longint'(it.pixel_index) + 1) * src - tgt;
    d = 2 * (src > tgt ? src : tgt);
    lo = floor_q(a - 3 * d, 2 * tgt);
    hi = floor_q(a + 3 * d, 2 * tgt) + 1;
    for (longint s = lo; s <= hi; s++) begin
      n = a - 2 * s * tgt;
      un = n < 0 ? -n : n;
      if (un >= 3 * d) continue;
      ti = (2 * un * KERNEL_STEPS + d) / (2 * d);
      if (ti >= KTAB_N) continue;
      w = ktab[ti];
      if (w == 0) continue;
      if (kept >= MAX_TAPS) begin
        clipped = 1;
        continue;
      end
      kept++;
      si = s < 0 ? 0 : (s > src - 1 ? src - 1 : s);
      for (int c = 0; c < 4; c++) acc[c] += longint'((line_mem[si] >> (8 * c)) & 8'hFF) * w;
      total += w;
    end
    r.target_index = it.pixel_index;
    r.taps_clipped = clipped;
    for (int c = 0; c < 4; c++) begin
      longint v;
      v = round_q(acc[c], total != 0 ? total : 16384);
      if (v < 0) v = 0;
      if (v > 255) v = 255;
      case (c)
        0: r.red_out = 8'(v);
        1: r.green_out = 8'(v);
        2: r.blue_out = 8'(v);
        default: r.alpha_out = 8'(v);
      endcase
    end
    pixel_exp_q = {pixel_exp_q, r};
  endfunction

  // Driver: gaps, optional hold until drained
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (start && !busy) begin
      resample_pixel(item_i);
      n_sent <= n_sent + 1;
    end
    if (start && busy) begin
      // item still waiting
    end else if (gap > 0 || (hold && pixel_exp_q.size() != 0) || pending_q.size() == 0) begin
      start <= 1'b0;
      if (gap > 0) gap <= gap - 1;
    end else begin
      item_i <= pending_q.pop_front();
      start <= 1'b1;
      gap <= ($urandom_range(0, 9) < 6) ? 0 :
             (($urandom_range(0, 9) < 8) ? $urandom_range(1, 3) : $urandom_range(10, 40));
    end
  end

  // Monitor
  always @(posedge clk_i) begin
    if (rst_ni && result_valid_o) begin
      if (pixel_exp_q.size() == 0) begin
        $error("unexpected result, target_index %0d", result_o.target_index);
        errors++;
      end else begin
        out_item_t e;
        e = pixel_exp_q.pop_front();
        if (result_o.target_index !== e.target_index) begin
          $error("target_index exp %0d got %0d", e.target_index, result_o.target_index);
          errors++;
        end
        if (result_o.red_out !== e.red_out) begin
          $error("red_out exp %0d got %0d", e.red_out, result_o.red_out);
          errors++;
        end
        if (result_o.green_out !== e.green_out) begin
          $error("green_out exp %0d got %0d", e.green_out, result_o.green_out);
          errors++;
        end
        if (result_o.blue_out !== e.blue_out) begin
          $error("blue_out exp %0d got %0d", e.blue_out, result_o.blue_out);
          errors++;
        end
        if (result_o.alpha_out !== e.alpha_out) begin
          $error("alpha_out exp %0d got %0d", e.alpha_out, result_o.alpha_out);
          errors++;
        end
        if (result_o.taps_clipped !== e.taps_clipped) begin
          $error("taps_clipped exp %0d got %0d", e.taps_clipped, result_o.taps_clipped);
          errors++;
        end
      end
    end
  end

  // Timeout
  always @(posedge clk_i) begin
    if (cycles > LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  function automatic in_item_t pixel_write(int idx);
    in_item_t it;
    it.opcode = OP_WRITE;
    it.pixel_index = LEN_W'(idx);
    it.red_in = 8'($urandom);
    it.green_in = 8'($urandom);
    it.blue_in = 8'($urandom);
    it.alpha_in = 8'($urandom);
    return it;
  endfunction

  function automatic in_item_t pixel_compute(int idx);
    in_item_t it;
    it = pixel_write(0);
    it.opcode = OP_COMPUTE;
    it.pixel_index = LEN_W'(idx);
    return it;
  endfunction

  // Wait until every queued item went out and every pixel came back
  task automatic drain();
    while (pending_q.size() != 0 || start || pixel_exp_q.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    while (busy) @(posedge clk_i);
  endtask

  task automatic write_len(reg_idx_e r, int unsigned v);
    cfg_index_i <= r;
    cfg_data_i <= CFG_W'(v);
    cfg_valid_i <= 1'b1;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    cfg_valid_i <= 1'b0;
    @(posedge clk_i);
    if (r == REG_SOURCE_LEN) src_len = v;
    else tgt_len = v;
  endtask

  // One phase: fill the source line, then ask for target pixels
  task automatic run_phase(int unsigned s, int unsigned t, int n_comp);
    int sl;
    drain();
    write_len(REG_SOURCE_LEN, s);
    write_len(REG_TARGET_LEN, t);
    sl = clamp_len(s);
    for (int i = 0; i < sl; i++) queue_item(pixel_write(i));
    for (int i = 0; i < n_comp; i++) begin
      if ($urandom_range(0, 9) == 0)
        queue_item(pixel_write($urandom_range(0, sl - 1)));
      else if ($urandom_range(0, 19) == 0)
        queue_item(pixel_compute($urandom_range(0, 1023)));
      else
        queue_item(pixel_compute($urandom_range(0, clamp_len(t) - 1)));
    end
  endtask

  initial begin
    int unsigned s, t;
    for (int i = 0; i < KTAB_N; i++) begin
      longint x, y, m;
      bit neg;
      x = sinc_fx(i, KERNEL_STEPS);
      y = sinc_fx(i, KTAB_N);
      neg = (x < 0) != (y < 0);
      m = ((x < 0 ? -x : x) * (y < 0 ? -y : y) + (64'd1 << 45)) >> 46;
      ktab[i] = neg ? -m : m;
    end
    src_len = 1;
    tgt_len = 1;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: reset lengths, extremes of pixel values, out-of-range compute
    queue_item(pixel_write(0));
    begin
      in_item_t it;
      it = pixel_write(1023);
      it.red_in = 8'hFF; it.green_in = 8'h00; it.blue_in = 8'hFF; it.alpha_in = 8'h00;
      queue_item(it);
      it = pixel_write(0);
      it.red_in = 8'hFF; it.green_in = 8'hFF; it.blue_in = 8'hFF; it.alpha_in = 8'hFF;
      queue_item(it);
    end
    queue_item(pixel_compute(0));
    queue_item(pixel_compute(1));
    queue_item(pixel_compute(1023));
    run_phase(0, 0, 2);           // zero lengths read as one
    run_phase(2047, 4, 3);        // above MAX_LEN clamps; heavy downscale clips taps
    run_phase(8, 1024, 6);        // upscale, edges
    run_phase(1, 7, 3);

    // Pause the sender until the block is empty
    drain();
    hold = 1'b1;
    run_phase(20, 13, 10);
    drain();
    hold = 1'b0;

    // Random phases: mostly small lines, a few larger
    while (n_sent < 1500) begin
      if ($urandom_range(0, 9) == 0) begin
        s = $urandom_range(100, 300);
        t = $urandom_range(1, 1024);
      end else begin
        s = $urandom_range(1, 40);
        t = $urandom_range(1, 60);
      end
      run_phase(s, t, $urandom_range(5, 40));
      drain();
    end

    drain();
    if (errors == 0) $display("SUCCESS");
    else $display("FAILURE");
    $finish;
  end

endmodule

[sim.f]
hw/rtl/lzr_pkg.sv
hw/rtl/lzr_ram.sv
hw/rtl/lzr_kern_rom.sv
hw/rtl/lzr_div.sv
hw/rtl/lanczos3_line_resampler.sv
sim/tb.sv
